// File: rtl/core/ptc_pkg.sv
// Package for the pressure and temperature compensation pipeline: types and constants.
package ptc_pkg;

  // Configuration register indices
  localparam logic [2:0] CFG_TEMP_COEFFS  = 3'd0;
  localparam logic [2:0] CFG_PRESS_A      = 3'd1;
  localparam logic [2:0] CFG_PRESS_B      = 3'd2;
  localparam logic [2:0] CFG_PRESS_NINE   = 3'd3;

  // Compensation constants
  localparam logic signed [33:0] OFFSET_FINE = 34'sd128000;
  localparam logic signed [63:0] PRESS_FULL  = 64'sd1048576;
  localparam logic signed [63:0] PRESS_SCALE = 64'sd3125;

  // Restoring divider depth, one quotient bit per stage
  localparam int DIV_STAGES = 64;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } ptc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic        [31:0] pressure_q24_8;
    logic               press_invalid;
  } ptc_out_t;

endpackage

// File: rtl/core/pressure_temperature_compensation.sv
// Pipelined barometric compensation: temperature, 64-bit pressure and pipelined divider.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid, in_stall, in_data     | into block
//   out     | out_valid, out_stall, out_data  | out of block
//   cfg     | cfg_valid, cfg_ready, cfg_index,| into block
//           | cfg_data                        |
//
// One item is taken every cycle while no result is stalled; the path is ten arithmetic
// stages, the 64-stage restoring divider (one quotient bit per stage) and five
// post-division stages. rst is synchronous and clears the stage valid bits and
// the calibration registers. A stalled result freezes the whole pipeline, and
// in_stall follows it in the same cycle; bubbles are carried, nothing is lost.
module pressure_temperature_compensation (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ptc_pkg::ptc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ptc_pkg::ptc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import ptc_pkg::*;

  // Calibration registers
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_a;
  logic [63:0] press_coeffs_b;
  logic [15:0] press_coeff_nine;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs      <= '0;
      press_coeffs_a   <= '0;
      press_coeffs_b   <= '0;
      press_coeff_nine <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TEMP_COEFFS: temp_coeffs      <= cfg_data[47:0];
        CFG_PRESS_A:     press_coeffs_a   <= cfg_data;
        CFG_PRESS_B:     press_coeffs_b   <= cfg_data;
        CFG_PRESS_NINE:  press_coeff_nine <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Coefficient slices
  logic        [15:0] t1;
  logic signed [15:0] t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs[15:0];
  assign t2 = $signed(temp_coeffs[31:16]);
  assign t3 = $signed(temp_coeffs[47:32]);
  assign p1 = $signed({48'd0, press_coeffs_a[15:0]});
  assign p2 = 64'($signed(press_coeffs_a[31:16]));
  assign p3 = 64'($signed(press_coeffs_a[47:32]));
  assign p4 = 64'($signed(press_coeffs_a[63:48]));
  assign p5 = 64'($signed(press_coeffs_b[15:0]));
  assign p6 = 64'($signed(press_coeffs_b[31:16]));
  assign p7 = 64'($signed(press_coeffs_b[47:32]));
  assign p8 = 64'($signed(press_coeffs_b[63:48]));
  assign p9 = 64'($signed(press_coeff_nine));

  // Global advance: the pipeline moves unless the output is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: capture raw samples
  logic        s1_v;
  logic [19:0] s1_at, s1_ap;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_at <= in_data.raw_temp;
      s1_ap <= in_data.raw_press;
    end
  end

  // Stage 2: first temperature products
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic               s2_v;
  logic signed [31:0] s2_a1p, s2_d2sq;
  logic        [19:0] s2_ap;

  assign d1 = $signed({1'b0, s1_at[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2 = $signed({1'b0, s1_at[19:4]}) - $signed({1'b0, t1});

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_a1p  <= 32'(d1) * 32'(t2);
      s2_d2sq <= 32'(d2) * 32'(d2);
      s2_ap   <= s1_ap;
    end
  end

  // Stage 3: second temperature term
  logic               s3_v;
  logic signed [31:0] s3_a1, s3_q;
  logic        [19:0] s3_ap;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_a1 <= s2_a1p >>> 11;
      s3_q  <= (s2_d2sq >>> 12) * 32'(t3);
      s3_ap <= s2_ap;
    end
  end

  // Stage 4: fine temperature
  logic               s4_v;
  logic signed [31:0] s4_fine;
  logic        [19:0] s4_ap;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_fine <= s3_a1 + (s3_q >>> 14);
      s4_ap   <= s3_ap;
    end
  end

  // Stage 5: temperature result and pressure offset
  logic               s5_v;
  logic signed [31:0] s5_temp;
  logic signed [33:0] s5_v1;
  logic        [19:0] s5_ap;

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en) s5_v <= s4_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_temp <= (s4_fine * 32'sd5 + 32'sd128) >>> 8;
      s5_v1   <= 34'(s4_fine) - OFFSET_FINE;
      s5_ap   <= s4_ap;
    end
  end

  // Stage 6: square and linear products of the offset
  logic               s6_v;
  logic signed [63:0] s6_vsq, s6_v1p5, s6_v1p2;
  logic signed [31:0] s6_temp;
  logic        [19:0] s6_ap;

  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else if (en) s6_v <= s5_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_vsq  <= 64'(s5_v1) * 64'(s5_v1);
      s6_v1p5 <= 64'(s5_v1) * p5;
      s6_v1p2 <= 64'(s5_v1) * p2;
      s6_temp <= s5_temp;
      s6_ap   <= s5_ap;
    end
  end

  // Stage 7: square times coefficients
  logic               s7_v;
  logic signed [63:0] s7_a, s7_b, s7_v1p5, s7_v1p2;
  logic signed [31:0] s7_temp;
  logic        [19:0] s7_ap;

  always_ff @(posedge clk) begin
    if (rst) s7_v <= 1'b0;
    else if (en) s7_v <= s6_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_a    <= s6_vsq * p6;
      s7_b    <= s6_vsq * p3;
      s7_v1p5 <= s6_v1p5;
      s7_v1p2 <= s6_v1p2;
      s7_temp <= s6_temp;
      s7_ap   <= s6_ap;
    end
  end

  // Stage 8: sums for the numerator and divisor terms
  logic               s8_v;
  logic signed [63:0] s8_v2, s8_v1b;
  logic signed [31:0] s8_temp;
  logic        [19:0] s8_ap;

  always_ff @(posedge clk) begin
    if (rst) s8_v <= 1'b0;
    else if (en) s8_v <= s7_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_v2   <= s7_a + (s7_v1p5 <<< 17) + (p4 <<< 35);
      s8_v1b  <= (s7_b >>> 8) + (s7_v1p2 <<< 12);
      s8_temp <= s7_temp;
      s8_ap   <= s7_ap;
    end
  end

  // Stage 9: divisor and numerator
  logic signed [63:0] pf;
  logic               s9_v;
  logic signed [63:0] s9_den, s9_num;
  logic signed [31:0] s9_temp;

  assign pf = PRESS_FULL - $signed({44'd0, s8_ap});

  always_ff @(posedge clk) begin
    if (rst) s9_v <= 1'b0;
    else if (en) s9_v <= s8_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s9_den  <= (((64'sd1 <<< 47) + s8_v1b) * p1) >>> 33;
      s9_num  <= ((pf <<< 31) - s8_v2) * PRESS_SCALE;
      s9_temp <= s8_temp;
    end
  end

  // Divider: entry 0 holds magnitudes and signs, each later entry one more bit
  logic               dv_v    [0:DIV_STAGES];
  logic        [63:0] dv_rem  [0:DIV_STAGES];
  logic        [63:0] dv_dq   [0:DIV_STAGES];
  logic        [63:0] dv_mb   [0:DIV_STAGES];
  logic               dv_neg  [0:DIV_STAGES];
  logic               dv_inv  [0:DIV_STAGES];
  logic signed [31:0] dv_temp [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= s9_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[0]  <= '0;
      dv_dq[0]   <= s9_num[63] ? 64'(-s9_num) : 64'(s9_num);
      dv_mb[0]   <= s9_den[63] ? 64'(-s9_den) : 64'(s9_den);
      dv_neg[0]  <= s9_num[63] ^ s9_den[63];
      dv_inv[0]  <= (s9_den == 64'sd0);
      dv_temp[0] <= s9_temp;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [63:0] r;
    logic        ge;

    // shift in the next dividend bit and try a subtract
    assign r  = {dv_rem[k][62:0], dv_dq[k][63]};
    assign ge = (r >= dv_mb[k]);

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (en) dv_v[k+1] <= dv_v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k+1]  <= ge ? (r - dv_mb[k]) : r;
        dv_dq[k+1]   <= {dv_dq[k][62:0], ge};
        dv_mb[k+1]   <= dv_mb[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_inv[k+1]  <= dv_inv[k];
        dv_temp[k+1] <= dv_temp[k];
      end
    end
  end

  // Stage 11: restore quotient sign
  logic               s11_v, s11_inv;
  logic signed [63:0] s11_p;
  logic signed [31:0] s11_temp;

  always_ff @(posedge clk) begin
    if (rst) s11_v <= 1'b0;
    else if (en) s11_v <= dv_v[DIV_STAGES];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s11_p    <= dv_neg[DIV_STAGES] ? -$signed(dv_dq[DIV_STAGES])
                                     : $signed(dv_dq[DIV_STAGES]);
      s11_inv  <= dv_inv[DIV_STAGES];
      s11_temp <= dv_temp[DIV_STAGES];
    end
  end

  // Stage 12: scaled quotient and single-coefficient products
  logic signed [63:0] ps;
  logic               s12_v, s12_inv;
  logic signed [63:0] s12_p, s12_ps, s12_w2, s12_t9;
  logic signed [31:0] s12_temp;

  assign ps = s11_p >>> 13;

  always_ff @(posedge clk) begin
    if (rst) s12_v <= 1'b0;
    else if (en) s12_v <= s11_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s12_p    <= s11_p;
      s12_ps   <= ps;
      s12_w2   <= (p8 * s11_p) >>> 19;
      s12_t9   <= p9 * ps;
      s12_inv  <= s11_inv;
      s12_temp <= s11_temp;
    end
  end

  // Stage 13: 32-bit partial products of the wide square term
  logic               s13_v, s13_inv;
  logic        [63:0] s13_pp0;
  logic        [31:0] s13_pp1, s13_pp2;
  logic signed [63:0] s13_p, s13_w2;
  logic signed [31:0] s13_temp;

  always_ff @(posedge clk) begin
    if (rst) s13_v <= 1'b0;
    else if (en) s13_v <= s12_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s13_pp0  <= 64'(s12_t9[31:0]) * 64'(s12_ps[31:0]);
      s13_pp1  <= s12_t9[63:32] * s12_ps[31:0];
      s13_pp2  <= s12_t9[31:0] * s12_ps[63:32];
      s13_p    <= s12_p;
      s13_w2   <= s12_w2;
      s13_inv  <= s12_inv;
      s13_temp <= s12_temp;
    end
  end

  // Stage 14: combine partial products
  logic        [63:0] wsq;
  logic               s14_v, s14_inv;
  logic signed [63:0] s14_w1, s14_p, s14_w2;
  logic signed [31:0] s14_temp;

  assign wsq = s13_pp0 + {s13_pp1 + s13_pp2, 32'd0};

  always_ff @(posedge clk) begin
    if (rst) s14_v <= 1'b0;
    else if (en) s14_v <= s13_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s14_w1   <= $signed(wsq) >>> 25;
      s14_p    <= s13_p;
      s14_w2   <= s13_w2;
      s14_inv  <= s13_inv;
      s14_temp <= s13_temp;
    end
  end

  // Stage 15: final sum, output register
  logic signed [63:0] pfin;
  ptc_out_t           res;

  assign pfin = ((s14_p + s14_w1 + s14_w2) >>> 8) + (p7 <<< 4);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s14_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res.temp_centi     <= s14_temp;
      res.pressure_q24_8 <= s14_inv ? 32'd0 : pfin[31:0];
      res.press_invalid  <= s14_inv;
    end
  end

  assign out_data = res;

endmodule

// File: rtl/core/ptc_checker.sv
// Port-level checker for the compensation pipeline, bound to the top level.
module ptc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ptc_pkg::ptc_out_t out_data
);
  import ptc_pkg::*;

  // held input stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input withdrawn while stalled");

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // input is held back exactly when the output is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // zero divisor gives zero pressure
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.press_invalid |-> out_data.pressure_q24_8 == 32'd0)
    else $error("invalid pressure not zero");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
